FILE: hw/rtl/tccw_pkg.sv
// ----------------------------------------------------------------------------
// tccw_pkg : shared definitions for the text console character writer
// Screen geometry, character codes, controller states and the command and
// status groups passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package tccw_pkg;

  // Screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int ADDR_W  = $clog2(CELLS);

  // Field widths
  localparam int CHAR_W  = 8;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int IN_W    = 24;
  localparam int OUT_W   = 24;

  // Character codes and tab spacing
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam int                TAB_STOP   = 8;
  localparam int                TAB_W      = $clog2(TAB_STOP);

  // Request kinds carried on in_tuser
  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Controller states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SWEEP
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;     // take the request on the input channel
    logic sweep;      // write one space cell of the running clear
    logic load_read;  // move registered read data into the result
  } ctl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_read;     // pending request is a cell read
    logic put_scroll;  // pending put scrolls the screen
    logic sweep_last;  // the clear is at its final cell
  } dp_sts_t;

endpackage

FILE: hw/rtl/text_console_char_writer.sv
// ----------------------------------------------------------------------------
// text_console_char_writer : character screen writer with cursor and scroll
// Put requests print, tab or break lines at the cursor; read requests
// return one logical screen cell. Scrolling moves a ring offset and clears
// the new bottom line to spaces.
// ----------------------------------------------------------------------------
// A put's result is registered on acceptance; a read's result is loaded
// in ST_READ. Puts are taken one per cycle while the result register is
// free; a read holds off the next request. A scrolling put is followed by
// a line clear (one cell per cycle through the single memory write port)
// before the next request. After reset a clearing pass fills the screen
// with spaces while in_tready is low; the cursor and top line start at zero.
module text_console_char_writer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [7:0] char_code, [12:8] read_row, [19:13] read_col, [23:20] zero
  input  logic [tccw_pkg::IN_W-1:0]   in_tdata,
  // [0] cmd
  input  logic                        in_tuser,
  input  logic                        in_tlast,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [7:0] cell_char, [14:8] cursor_col, [19:15] cursor_row, [20] scrolled,
  // [23:21] zero
  output logic [tccw_pkg::OUT_W-1:0]  out_tdata,
  output logic                        out_tlast
);
  import tccw_pkg::*;

  ctl_cmd_t ctl_cmd;
  dp_sts_t  dp_sts;

  // Controller
  tccw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (dp_sts),
    .cmd        (ctl_cmd)
  );

  // Datapath
  tccw_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (ctl_cmd),
    .sts       (dp_sts),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  // A request is only taken when the result register can accept its result.
  a_free_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!out_tvalid || out_tready))
    else $error("request taken while the result register is full");

  // A read result is held back while the read is in ST_READ, then becomes valid.
  a_read_timing: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == CMD_READ) |=> (!out_tvalid ##1 out_tvalid))
    else $error("read result timing broken");

  // The reported cursor is always on the screen.
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[14:8] < COL_W'(COLUMNS)) &&
                    (out_tdata[19:15] < ROW_W'(ROWS))))
    else $error("cursor outside the screen");

endmodule

FILE: hw/rtl/tccw_ctrl.sv
// ----------------------------------------------------------------------------
// tccw_ctrl : controller for the text console character writer
// Sequences the reset clear, request acceptance, registered reads and the
// line clear after a scroll, and owns the result valid flag.
// ----------------------------------------------------------------------------
module tccw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  tccw_pkg::dp_sts_t sts,
  output tccw_pkg::ctl_cmd_t cmd
);
  import tccw_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // State and valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The result register is free when empty or being taken this cycle.
  assign out_free = !out_valid_r || out_tready;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_tready     = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      ST_CLEAR: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = out_free;
        if (in_tvalid && out_free) begin
          cmd.accept = 1'b1;
          if (sts.is_read) begin
            state_nxt = ST_READ;
          end else begin
            out_valid_nxt = 1'b1;
            if (sts.put_scroll) begin
              state_nxt = ST_SWEEP;
            end
          end
        end
      end
      ST_READ: begin
        cmd.load_read = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

FILE: hw/rtl/tccw_dpath.sv
// ----------------------------------------------------------------------------
// tccw_dpath : datapath for the text console character writer
// Holds the screen memory, the cursor, the ring offset of the top line,
// the clear address counter and the result register.
// ----------------------------------------------------------------------------
module tccw_dpath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tccw_pkg::ctl_cmd_t             cmd,
  output tccw_pkg::dp_sts_t              sts,
  input  logic [tccw_pkg::IN_W-1:0]      in_tdata,
  input  logic                           in_tuser,
  input  logic                           in_tlast,
  output logic [tccw_pkg::OUT_W-1:0]     out_tdata,
  output logic                           out_tlast
);
  import tccw_pkg::*;

  // Screen memory, physical line order
  logic [CHAR_W-1:0] mem [CELLS];

  // Cursor, ring offset and clear counter
  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  row_r;
  logic [ROW_W-1:0]  top_r;
  logic [ADDR_W-1:0] sw_addr_r;
  logic [ADDR_W-1:0] sw_end_r;

  // Read path and result register
  logic [CHAR_W-1:0] rd_data_r;
  logic              rd_ok_r;
  logic [CHAR_W-1:0] res_cell_r;
  logic [COL_W-1:0]  res_col_r;
  logic [ROW_W-1:0]  res_row_r;
  logic              res_scroll_r;
  logic              res_move_r;

  // Request fields
  logic [CHAR_W-1:0] code;
  logic [ROW_W-1:0]  rrow;
  logic [COL_W-1:0]  rcol;
  logic              is_read;

  // Put datapath
  logic [COL_W:0]    col_nxt;
  logic [ROW_W:0]    row_ext;
  logic [ROW_W-1:0]  row_nxt;
  logic              scroll;
  logic              wr_char;
  logic [ADDR_W-1:0] wr_addr;
  logic [ROW_W-1:0]  top_nxt;
  logic [ADDR_W-1:0] base_addr;

  // Read datapath
  logic              rd_ok;
  logic [ADDR_W-1:0] rd_addr;

  // Memory write port
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [CHAR_W-1:0] mem_wd;

  // Map a logical row to its physical line through the ring offset.
  function automatic logic [ROW_W-1:0] phys_line(input logic [ROW_W-1:0] lrow,
                                                  input logic [ROW_W-1:0] top);
    logic [ROW_W:0] s;
    s = {1'b0, lrow} + {1'b0, top};
    if (s >= (ROW_W+1)'(ROWS)) begin
      s = s - (ROW_W+1)'(ROWS);
    end
    return s[ROW_W-1:0];
  endfunction

  assign code    = in_tdata[7:0];
  assign rrow    = in_tdata[12:8];
  assign rcol    = in_tdata[19:13];
  assign is_read = (in_tuser == CMD_READ);

  // Cursor step for one put request.
  always_comb begin
    wr_char = 1'b0;
    scroll  = 1'b0;
    row_ext = {1'b0, row_r};
    if (code == CH_NEWLINE) begin
      col_nxt = '0;
      row_ext = {1'b0, row_r} + (ROW_W+1)'(1);
    end else if (code == CH_TAB) begin
      col_nxt = ((({1'b0, col_r}) >> TAB_W) + (COL_W+1)'(1)) << TAB_W;
    end else begin
      col_nxt = {1'b0, col_r} + (COL_W+1)'(1);
      wr_char = 1'b1;
    end
    if (col_nxt >= (COL_W+1)'(COLUMNS)) begin
      col_nxt = '0;
      row_ext = row_ext + (ROW_W+1)'(1);
    end
    if (row_ext >= (ROW_W+1)'(ROWS)) begin
      scroll  = 1'b1;
      row_ext = (ROW_W+1)'(ROWS - 1);
    end
    row_nxt = row_ext[ROW_W-1:0];
  end

  // Addresses for the character write, the read and the line to clear.
  assign wr_addr   = ADDR_W'(phys_line(row_r, top_r)) * ADDR_W'(COLUMNS) + ADDR_W'(col_r);
  assign rd_ok     = (rrow < ROW_W'(ROWS)) && ({1'b0, rcol} < (COL_W+1)'(COLUMNS));
  assign rd_addr   = rd_ok ? (ADDR_W'(phys_line(rrow, top_r)) * ADDR_W'(COLUMNS)
                              + ADDR_W'(rcol)) : '0;
  assign top_nxt   = (top_r == ROW_W'(ROWS - 1)) ? '0 : top_r + ROW_W'(1);
  assign base_addr = ADDR_W'(top_r) * ADDR_W'(COLUMNS);

  // Memory write select: a character on a put, a space during a clear.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = wr_addr;
    mem_wd = code;
    if (cmd.sweep) begin
      mem_we = 1'b1;
      mem_wa = sw_addr_r;
      mem_wd = CH_SPACE;
    end else if (cmd.accept && !is_read && wr_char) begin
      mem_we = 1'b1;
    end
  end

  // Screen memory with registered read data
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.accept) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Cursor, ring offset and clear counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      top_r     <= '0;
      sw_addr_r <= '0;
      sw_end_r  <= ADDR_W'(CELLS - 1);
    end else begin
      if (cmd.accept && !is_read) begin
        col_r <= col_nxt[COL_W-1:0];
        row_r <= row_nxt;
        if (scroll) begin
          top_r     <= top_nxt;
          sw_addr_r <= base_addr;
          sw_end_r  <= base_addr + ADDR_W'(COLUMNS - 1);
        end
      end else if (cmd.sweep) begin
        sw_addr_r <= sw_addr_r + ADDR_W'(1);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_ok_r <= rd_ok;
      if (is_read) begin
        res_col_r    <= col_r;
        res_row_r    <= row_r;
        res_scroll_r <= 1'b0;
        res_move_r   <= 1'b0;
      end else begin
        res_cell_r   <= '0;
        res_col_r    <= col_nxt[COL_W-1:0];
        res_row_r    <= row_nxt;
        res_scroll_r <= scroll;
        res_move_r   <= in_tlast;
      end
    end
    if (cmd.load_read) begin
      res_cell_r <= rd_ok_r ? rd_data_r : '0;
    end
  end

  assign sts.is_read    = is_read;
  assign sts.put_scroll = scroll;
  assign sts.sweep_last = (sw_addr_r == sw_end_r);

  assign out_tdata = {3'b000, res_scroll_r, res_row_r, res_col_r, res_cell_r};
  assign out_tlast = res_move_r;

endmodule
